// ===== src/rgb2hsv_pkg.sv =====
// Types and constants for the RGB to HSV conversion core.
// No dependencies; used by every module in src.
package rgb2hsv_pkg;

	localparam int unsigned CompBits  = 8;
	localparam int unsigned FracBits  = 16;
	localparam int unsigned HueDBits  = 11;
	localparam int unsigned CellCount = FracBits;
	localparam int unsigned Latency   = CellCount + 1;

	typedef struct packed {
		logic [CompBits-1:0] red_in;
		logic [CompBits-1:0] green_in;
		logic [CompBits-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [FracBits-1:0] hue_out;
		logic [FracBits-1:0] sat_out;
		logic [CompBits-1:0] value_out;
	} hsv_t;

	typedef struct packed {
		logic [HueDBits-1:0] hue_rem;
		logic [HueDBits-1:0] hue_den;
		logic [FracBits-1:0] hue_q;
		logic [CompBits-1:0] sat_rem;
		logic [CompBits-1:0] sat_den;
		logic [FracBits-1:0] sat_q;
		logic                sat_full;
		logic [CompBits-1:0] value;
	} div_word_t;

endpackage

// ===== src/rgb2hsv_front.sv =====
// Front stage: max, min, hue sector and divider operands for one pixel.
// Depends on rgb2hsv_pkg.
module rgb2hsv_front
	import rgb2hsv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  pixel_t    pixel,
	output logic      out_valid,
	output div_word_t out_word
);

	logic [CompBits-1:0] r, g, b, mx, mn, d;
	logic [CompBits:0]   n;
	logic [HueDBits-1:0] kd, d6;
	logic [HueDBits:0]   num;
	div_word_t           word;

	always_comb begin
		r  = pixel.red_in;
		g  = pixel.green_in;
		b  = pixel.blue_in;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		d  = mx - mn;
		d6 = ({3'b000, d} << 2) + ({3'b000, d} << 1);
		priority if (r == mx) begin
			n  = {1'b0, g} - {1'b0, b};
			kd = n[CompBits] ? d6 : '0;
		end else if (g == mx) begin
			n  = {1'b0, b} - {1'b0, r};
			kd = {2'b00, d, 1'b0};
		end else begin
			n  = {1'b0, r} - {1'b0, g};
			kd = {1'b0, d, 2'b00};
		end
		num = {{(HueDBits-CompBits){n[CompBits]}}, n} + {1'b0, kd};

		word.hue_rem  = num[HueDBits-1:0];
		word.hue_den  = (d == '0) ? HueDBits'(6) : d6;
		word.hue_q    = '0;
		word.sat_rem  = d;
		word.sat_den  = (mx == '0) ? CompBits'(1) : mx;
		word.sat_q    = '0;
		word.sat_full = (d == mx) && (mx != '0);
		word.value    = mx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			out_word <= word;
		end
	end

endmodule

// ===== src/rgb2hsv_cell.sv =====
// Divider cell: one restoring step of both the hue and saturation quotients.
// Depends on rgb2hsv_pkg.
module rgb2hsv_cell
	import rgb2hsv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_word_t in_word,
	output logic      out_valid,
	output div_word_t out_word
);

	logic [HueDBits:0]  hue_sh, hue_sub;
	logic [CompBits:0]  sat_sh, sat_sub;
	logic               hue_ge, sat_ge;
	div_word_t          word;

	always_comb begin
		hue_sh  = {in_word.hue_rem, 1'b0};
		hue_sub = hue_sh - {1'b0, in_word.hue_den};
		hue_ge  = hue_sh >= {1'b0, in_word.hue_den};
		sat_sh  = {in_word.sat_rem, 1'b0};
		sat_sub = sat_sh - {1'b0, in_word.sat_den};
		sat_ge  = sat_sh >= {1'b0, in_word.sat_den};

		word         = in_word;
		word.hue_rem = hue_ge ? hue_sub[HueDBits-1:0] : hue_sh[HueDBits-1:0];
		word.hue_q   = {in_word.hue_q[FracBits-2:0], hue_ge};
		word.sat_rem = sat_ge ? sat_sub[CompBits-1:0] : sat_sh[CompBits-1:0];
		word.sat_q   = {in_word.sat_q[FracBits-2:0], sat_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			out_word <= word;
		end
	end

endmodule

// ===== src/rgb_to_hsv_convert_core.sv =====
// Top level of the RGB to HSV core: front stage followed by a row of divider cells.
// Depends on rgb2hsv_pkg, rgb2hsv_front and rgb2hsv_cell.
//
//   port      dir  word     handshake
//   pixel     in   pixel_t  taken when start is high and busy is low
//   hsv       out  hsv_t    valid for one cycle while done is high
//
// One pixel may be started every clock; busy stays low.
// A result passes through one front stage, then 16 divider cells,
// each producing one quotient bit of hue and of saturation per cycle.
// Reset clears the valid bits of all stages; words in flight are dropped.
// The receiver cannot stall, so no word is ever held back.
module rgb_to_hsv_convert_core
	import rgb2hsv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  pixel_t pixel,
	output logic   done,
	output hsv_t   hsv
);

	logic      stage_v [CellCount+1];
	div_word_t stage_w [CellCount+1];

	assign busy = 1'b0;

	rgb2hsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.pixel     (pixel),
		.out_valid (stage_v[0]),
		.out_word  (stage_w[0])
	);

	for (genvar i = 0; i < CellCount; i++) begin : g_cell
		rgb2hsv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_v[i]),
			.in_word   (stage_w[i]),
			.out_valid (stage_v[i+1]),
			.out_word  (stage_w[i+1])
		);
	end

	always_comb begin
		done          = stage_v[CellCount];
		hsv.hue_out   = stage_w[CellCount].hue_q;
		hsv.sat_out   = stage_w[CellCount].sat_full ? '1 : stage_w[CellCount].sat_q;
		hsv.value_out = stage_w[CellCount].value;
	end

	a_black_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hsv.value_out == '0) |-> (hsv.sat_out == '0))
		else $error("saturation nonzero for black pixel");

	a_hue_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stage_v[CellCount] |-> (stage_w[CellCount].hue_rem < stage_w[CellCount].hue_den))
		else $error("hue remainder out of range");

	a_sat_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_v[0] && !stage_w[0].sat_full) |->
			(stage_w[0].sat_rem < stage_w[0].sat_den))
		else $error("saturation operand out of range");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(stage_v[CellCount-1]))
		else $error("done without word in last cell");

endmodule
